### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by the rotation checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define RVEC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RVEC_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rvec_pkg.sv
// ----------------------------------------------------------------------------
// rvec_pkg
// Shared constants and the CORDIC arctangent table for the vector rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package rvec_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int PH_BITS      = 32;  // phase word, 2^32 per turn
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;  // datapath width of the CORDIC stages
  localparam int COEF_W       = 32;  // sin/cos in Q1.30
  localparam int FRAC_BITS    = 30;
  localparam int MIX_STAGES   = 4;

  localparam logic [PH_BITS-1:0] CORDIC_GAIN = 32'd652032874;

  localparam logic KIND_Z = 1'b1;

  function automatic logic [PH_BITS-1:0] atan_val(input int unsigned idx);
    logic [PH_BITS-1:0] v;
    case (idx)
      0:  v = 32'h2000_0000;
      1:  v = 32'h12E4_051E;
      2:  v = 32'h09FB_385B;
      3:  v = 32'h0511_11D4;
      4:  v = 32'h028B_0D43;
      5:  v = 32'h0145_D7E1;
      6:  v = 32'h00A2_F61E;
      7:  v = 32'h0051_7C55;
      8:  v = 32'h0028_BE53;
      9:  v = 32'h0014_5F2F;
      10: v = 32'h000A_2F98;
      11: v = 32'h0005_17CC;
      12: v = 32'h0002_8BE6;
      13: v = 32'h0001_45F3;
      14: v = 32'h0000_A2FA;
      15: v = 32'h0000_517D;
      16: v = 32'h0000_28BE;
      17: v = 32'h0000_145F;
      18: v = 32'h0000_0A30;
      19: v = 32'h0000_0518;
      20: v = 32'h0000_028C;
      21: v = 32'h0000_0146;
      22: v = 32'h0000_00A3;
      23: v = 32'h0000_0051;
      24: v = 32'h0000_0029;
      25: v = 32'h0000_0014;
      26: v = 32'h0000_000A;
      27: v = 32'h0000_0005;
      28: v = 32'h0000_0003;
      29: v = 32'h0000_0001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/rvec_if.sv
// ----------------------------------------------------------------------------
// rvec_if
// Valid/ready channels for the point stream in and the rotated point out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvec_in_if #(
  parameter int COORD_BITS = rvec_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = rvec_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ANGLE_BITS-1:0]        angle;
  logic signed [COORD_BITS-1:0] x_in;
  logic signed [COORD_BITS-1:0] y_in;
  logic signed [COORD_BITS-1:0] z_in;

  modport source (output valid, kind, angle, x_in, y_in, z_in, input ready);
  modport sink   (input valid, kind, angle, x_in, y_in, z_in, output ready);
endinterface

interface rvec_out_if #(
  parameter int COORD_BITS = rvec_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_out;
  logic signed [COORD_BITS-1:0] y_out;
  logic signed [COORD_BITS-1:0] z_out;

  modport source (output valid, x_out, y_out, z_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

`default_nettype wire

### rtl/rvec_cordic.sv
// ----------------------------------------------------------------------------
// rvec_cordic
// Pipelined rotation-mode CORDIC: binary angle in, Q1.30 cos/sin out,
// one iteration per stage, side payload carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rvec_cordic #(
  parameter int ANGLE_BITS = rvec_pkg::ANGLE_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              valid_in,
  input  wire logic [ANGLE_BITS-1:0]             angle,
  input  wire logic [SIDE_W-1:0]                 side_in,
  output logic                                   valid_out,
  output logic signed [rvec_pkg::COEF_W-1:0]     cos_out,
  output logic signed [rvec_pkg::COEF_W-1:0]     sin_out,
  output logic [SIDE_W-1:0]                      side_out
);

  localparam int STEPS = rvec_pkg::CORDIC_STEPS;
  localparam int CW    = rvec_pkg::CORDIC_W;
  localparam int PW    = rvec_pkg::PH_BITS;
  localparam int KW    = rvec_pkg::COEF_W;

  logic signed [CW-1:0] x_r    [0:STEPS];
  logic signed [CW-1:0] y_r    [0:STEPS];
  logic signed [CW-1:0] z_r    [0:STEPS];
  logic                 flip_r [0:STEPS];
  logic                 v_r    [0:STEPS];
  logic [SIDE_W-1:0]    side_r [0:STEPS];

  logic [PW-1:0]        ph;
  logic                 flip_nxt;
  logic [PW-1:0]        ph_fold;

  // quadrants 1 and 2 fold onto 3 and 0 by a half turn
  always_comb begin
    ph       = {angle, {(PW-ANGLE_BITS){1'b0}}};
    flip_nxt = (ph[PW-1:PW-2] == 2'b01) || (ph[PW-1:PW-2] == 2'b10);
    ph_fold  = flip_nxt ? (ph ^ {1'b1, {(PW-1){1'b0}}}) : ph;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= $signed({{(CW-PW){1'b0}}, rvec_pkg::CORDIC_GAIN});
      y_r[0]    <= '0;
      z_r[0]    <= $signed({{(CW-PW){ph_fold[PW-1]}}, ph_fold});
      flip_r[0] <= flip_nxt;
      side_r[0] <= side_in;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic [PW-1:0] ATAN = rvec_pkg::atan_val(i);
    logic signed [CW-1:0] at;
    logic signed [CW-1:0] x_nxt;
    logic signed [CW-1:0] y_nxt;
    logic signed [CW-1:0] z_nxt;

    always_comb begin
      at = $signed({{(CW-PW){1'b0}}, ATAN});
      if (!z_r[i][CW-1]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - at;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        flip_r[i+1] <= flip_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  logic signed [CW-1:0] xn;
  logic signed [CW-1:0] yn;
  logic signed [KW-1:0] cos_nxt;
  logic signed [KW-1:0] sin_nxt;
  logic signed [KW-1:0] cos_r;
  logic signed [KW-1:0] sin_r;
  logic                 vo_r;
  logic [SIDE_W-1:0]    so_r;

  always_comb begin
    xn      = -x_r[STEPS];
    yn      = -y_r[STEPS];
    cos_nxt = flip_r[STEPS] ? xn[KW-1:0] : x_r[STEPS][KW-1:0];
    sin_nxt = flip_r[STEPS] ? yn[KW-1:0] : y_r[STEPS][KW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
      so_r  <= side_r[STEPS];
    end
  end

  assign valid_out = vo_r;
  assign cos_out   = cos_r;
  assign sin_out   = sin_r;
  assign side_out  = so_r;

endmodule

`default_nettype wire

### rtl/rvec_mix.sv
// ----------------------------------------------------------------------------
// rvec_mix
// Four-stage product unit: r0 = round((a*c - b*s) / 2^30),
// r1 = round((a*s + b*c) / 2^30), both saturated to the coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module rvec_mix #(
  parameter int COORD_BITS = rvec_pkg::COORD_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               valid_in,
  input  wire logic signed [COORD_BITS-1:0]       a_in,
  input  wire logic signed [COORD_BITS-1:0]       b_in,
  input  wire logic signed [rvec_pkg::COEF_W-1:0] c_in,
  input  wire logic signed [rvec_pkg::COEF_W-1:0] s_in,
  input  wire logic [SIDE_W-1:0]                  side_in,
  output logic                                    valid_out,
  output logic signed [COORD_BITS-1:0]            r0_out,
  output logic signed [COORD_BITS-1:0]            r1_out,
  output logic [SIDE_W-1:0]                       side_out
);

  localparam int KW    = rvec_pkg::COEF_W;
  localparam int FB    = rvec_pkg::FRAC_BITS;
  localparam int NS    = rvec_pkg::MIX_STAGES;
  localparam int LO    = COORD_BITS / 2;
  localparam int HI    = COORD_BITS - LO;
  localparam int PH_W  = HI + KW;
  localparam int PL_W  = LO + 1 + KW;
  localparam int SH_W  = PH_W + 1;
  localparam int SL_W  = PL_W + 1;
  localparam int ACC_W = COORD_BITS + KW + 1;

  localparam logic signed [ACC_W-1:0] RND =
    $signed({{(ACC_W-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}});
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    $signed({{(ACC_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    $signed({{(ACC_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}});

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [ACC_W-1:0] t);
    logic signed [ACC_W-1:0] q;
    logic signed [COORD_BITS-1:0] r;
    q = t >>> FB;
    if (q > SAT_MAX) begin
      r = SAT_MAX[COORD_BITS-1:0];
    end else if (q < SAT_MIN) begin
      r = SAT_MIN[COORD_BITS-1:0];
    end else begin
      r = q[COORD_BITS-1:0];
    end
    return r;
  endfunction

  logic [NS-1:0]     v_r;
  logic [SIDE_W-1:0] side_r [0:NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int k = 1; k < NS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stage 1: split products
  logic signed [HI-1:0]   ah;
  logic signed [HI-1:0]   bh;
  logic signed [LO:0]     al;
  logic signed [LO:0]     bl;
  logic signed [PH_W-1:0] ahc_r, ahs_r, bhc_r, bhs_r;
  logic signed [PL_W-1:0] alc_r, als_r, blc_r, bls_r;

  always_comb begin
    ah = a_in[COORD_BITS-1:LO];
    bh = b_in[COORD_BITS-1:LO];
    al = $signed({1'b0, a_in[LO-1:0]});
    bl = $signed({1'b0, b_in[LO-1:0]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ahc_r <= ah * c_in;
      ahs_r <= ah * s_in;
      bhc_r <= bh * c_in;
      bhs_r <= bh * s_in;
      alc_r <= al * c_in;
      als_r <= al * s_in;
      blc_r <= bl * c_in;
      bls_r <= bl * s_in;
    end
  end

  // stage 2: partial sums
  logic signed [SH_W-1:0] h0_r, h1_r;
  logic signed [SL_W-1:0] l0_r, l1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h0_r <= $signed({ahc_r[PH_W-1], ahc_r}) - $signed({bhs_r[PH_W-1], bhs_r});
      h1_r <= $signed({ahs_r[PH_W-1], ahs_r}) + $signed({bhc_r[PH_W-1], bhc_r});
      l0_r <= $signed({alc_r[PL_W-1], alc_r}) - $signed({bls_r[PL_W-1], bls_r});
      l1_r <= $signed({als_r[PL_W-1], als_r}) + $signed({blc_r[PL_W-1], blc_r});
    end
  end

  // stage 3: recombine and add the rounding half
  logic signed [ACC_W-1:0] t0_nxt, t1_nxt, t0_r, t1_r;

  always_comb begin
    t0_nxt = ($signed({{(ACC_W-SH_W){h0_r[SH_W-1]}}, h0_r}) <<< LO)
           + $signed({{(ACC_W-SL_W){l0_r[SL_W-1]}}, l0_r}) + RND;
    t1_nxt = ($signed({{(ACC_W-SH_W){h1_r[SH_W-1]}}, h1_r}) <<< LO)
           + $signed({{(ACC_W-SL_W){l1_r[SL_W-1]}}, l1_r}) + RND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
    end
  end

  // stage 4: scale and saturate
  logic signed [COORD_BITS-1:0] r0_r, r1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r <= sat(t0_r);
      r1_r <= sat(t1_r);
    end
  end

  assign valid_out = v_r[NS-1];
  assign r0_out    = r0_r;
  assign r1_out    = r1_r;
  assign side_out  = side_r[NS-1];

endmodule

`default_nettype wire

### rtl/axis_rotate_vector.sv
// ----------------------------------------------------------------------------
// axis_rotate_vector
// Rotates a signed Q16.16 point about the X or Z axis by a binary angle.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind, angle, x_in, y_in, z_in
//   out_ch   out  valid/ready    x_out, y_out, z_out
//
// One transfer per cycle sustained unless out_ch stalls. 36 register
// stages: phase fold, 30 CORDIC iterations and the sign fix, then 4
// product stages.
// Reset clears the valid bits only; the datapath registers are not reset.
// While out_ch holds a result that is not taken, the whole pipeline stalls
// and in_ch.ready is low; with the output empty or taken, ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_rotate_vector #(
  parameter int COORD_BITS = rvec_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = rvec_pkg::ANGLE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rvec_in_if.sink     in_ch,
  rvec_out_if.source  out_ch
);

  localparam int KW      = rvec_pkg::COEF_W;
  localparam int CSIDE_W = 1 + 3 * COORD_BITS;
  localparam int MSIDE_W = 1 + COORD_BITS;

  logic en;
  logic mix_valid;

  assign en          = !mix_valid || out_ch.ready;
  assign in_ch.ready = en;

  // pick the rotated pair and the pass-through coordinate up front
  logic                         kind_in;
  logic signed [COORD_BITS-1:0] u_in, v_in, p_in;

  always_comb begin
    kind_in = in_ch.kind;
    if (kind_in == rvec_pkg::KIND_Z) begin
      u_in = in_ch.x_in;
      v_in = in_ch.y_in;
      p_in = in_ch.z_in;
    end else begin
      u_in = in_ch.y_in;
      v_in = in_ch.z_in;
      p_in = in_ch.x_in;
    end
  end

  logic                 cor_valid;
  logic signed [KW-1:0] cos_w, sin_w;
  logic [CSIDE_W-1:0]   cside;

  rvec_cordic #(
    .ANGLE_BITS (ANGLE_BITS),
    .SIDE_W     (CSIDE_W)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (in_ch.valid),
    .angle     (in_ch.angle),
    .side_in   ({kind_in, u_in, v_in, p_in}),
    .valid_out (cor_valid),
    .cos_out   (cos_w),
    .sin_out   (sin_w),
    .side_out  (cside)
  );

  logic signed [COORD_BITS-1:0] r0, r1, pass;
  logic                         kind_o;
  logic [MSIDE_W-1:0]           mside;

  rvec_mix #(
    .COORD_BITS (COORD_BITS),
    .SIDE_W     (MSIDE_W)
  ) u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (cor_valid),
    .a_in      (cside[3*COORD_BITS-1:2*COORD_BITS]),
    .b_in      (cside[2*COORD_BITS-1:COORD_BITS]),
    .c_in      (cos_w),
    .s_in      (sin_w),
    .side_in   ({cside[CSIDE_W-1], cside[COORD_BITS-1:0]}),
    .valid_out (mix_valid),
    .r0_out    (r0),
    .r1_out    (r1),
    .side_out  (mside)
  );

  always_comb begin
    kind_o = mside[MSIDE_W-1];
    pass   = mside[COORD_BITS-1:0];
    if (kind_o == rvec_pkg::KIND_Z) begin
      out_ch.x_out = r0;
      out_ch.y_out = r1;
      out_ch.z_out = pass;
    end else begin
      out_ch.x_out = pass;
      out_ch.y_out = r0;
      out_ch.z_out = r1;
    end
  end

  assign out_ch.valid = mix_valid;

endmodule

`default_nettype wire

### rtl/rvec_chk.sv
// ----------------------------------------------------------------------------
// rvec_chk
// Port-level checks on the vector rotator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rvec_chk #(
  parameter int COORD_BITS = rvec_pkg::COORD_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [COORD_BITS-1:0] x_out,
  input wire logic [COORD_BITS-1:0] y_out,
  input wire logic [COORD_BITS-1:0] z_out
);

  logic                    slot_free;
  logic                    stall;
  logic [3*COORD_BITS-1:0] out_data;

  assign slot_free = !out_valid || out_ready;
  assign stall     = out_valid && !out_ready;
  assign out_data  = {x_out, y_out, z_out};

  // pipeline never refuses input when the output slot is free
  `RVEC_ASSERT_RST(a_ready_free, clk, rst_n, slot_free |-> in_ready, "in_ready low, output free")

  `RVEC_ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid, "out valid after reset")

  `RVEC_ASSERT_RST(a_out_hold, clk, rst_n, stall |=> out_valid, "out transfer dropped")

  `RVEC_ASSERT_RST(a_out_stable, clk, rst_n, stall |=> $stable(out_data), "out payload changed")

  // a stalled result also freezes the input side
  `RVEC_ASSERT_RST(a_stall_back, clk, rst_n, stall |-> !in_ready, "input taken during stall")

endmodule

bind axis_rotate_vector rvec_chk #(
  .COORD_BITS (COORD_BITS)
) u_rvec_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .x_out     (out_ch.x_out),
  .y_out     (out_ch.y_out),
  .z_out     (out_ch.z_out)
);

`default_nettype wire

### tb/rvec_tb_pkg.sv
// ----------------------------------------------------------------------------
// rvec_tb_pkg
// Expected-result model and scoreboard for the axis rotator: a bit-exact
// CORDIC sine/cosine, exact Q1.30 products with round-half-up and saturation,
// and an in-order queue of expected rotated points.
// ----------------------------------------------------------------------------
package rvec_tb_pkg;

  localparam int CW = rvec_pkg::COORD_BITS_DEF;
  localparam int AW = rvec_pkg::ANGLE_BITS_DEF;

  localparam logic KIND_X = ~rvec_pkg::KIND_Z;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  localparam int     ITERS    = 30;
  localparam longint GAIN_Q30 = 64'd652032874;
  localparam logic [31:0] ARCTAN_TURN [ITERS] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001
  };

  class rotation_scoreboard;
    point_t      expected_points[$];
    int unsigned matched;
    int unsigned mismatches;
    int unsigned saturated;

    // quadrant fold, then rotation-mode CORDIC; cos/sin in Q1.30
    function void sin_cos(input logic [AW-1:0] angle, output longint c, output longint s);
      logic [31:0] phase;
      logic        flip;
      longint      x, y, z, dx, dy;
      phase = 32'(angle) << (32 - AW);
      flip  = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
      if (flip) phase += 32'h8000_0000;
      x = GAIN_Q30;
      y = 0;
      z = longint'(signed'(phase));
      for (int i = 0; i < ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'(ARCTAN_TURN[i]);
        end else begin
          x += dx;
          y -= dy;
          z += longint'(ARCTAN_TURN[i]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // round((a*ca + b*cb) / 2^30), halves up, clipped to the coordinate range
    function coord_t blend(coord_t a, longint ca, coord_t b, longint cb);
      logic signed [95:0] wa, wb, wca, wcb, acc, hi_lim, lo_lim;
      wa     = a;
      wb     = b;
      wca    = ca;
      wcb    = cb;
      hi_lim = CMAX;
      lo_lim = CMIN;
      acc    = wa * wca + wb * wcb + (96'sd1 <<< 29);
      acc    = acc >>> 30;
      if (acc > hi_lim) begin
        saturated++;
        return CMAX;
      end
      if (acc < lo_lim) begin
        saturated++;
        return CMIN;
      end
      return coord_t'(acc[CW-1:0]);
    endfunction

    function point_t rotate_point(logic kind, logic [AW-1:0] angle, point_t p);
      point_t r;
      longint c, s;
      sin_cos(angle, c, s);
      r = p;
      if (kind == rvec_pkg::KIND_Z) begin
        r.x = blend(p.x, c, p.y, -s);
        r.y = blend(p.x, s, p.y, c);
      end else begin
        r.y = blend(p.y, c, p.z, -s);
        r.z = blend(p.y, s, p.z, c);
      end
      return r;
    endfunction

    function void note_point(logic kind, logic [AW-1:0] angle, point_t p);
      expected_points.push_back(rotate_point(kind, angle, p));
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: point mismatch: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                   want.x, want.y, want.z, got.x, got.y, got.z);
      end else begin
        matched++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream test of axis_rotate_vector: directed extremes and quadrant edges,
// then random points under three idle/stall mixes, every result checked in
// order against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 400;
  localparam int DRAIN_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam int AW          = rvec_tb_pkg::AW;

  logic clk;
  logic rst_n;

  rvec_in_if  in_ch ();
  rvec_out_if out_ch ();

  axis_rotate_vector u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rvec_tb_pkg::rotation_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned x_axis_cnt    = 0;
  int unsigned z_axis_cnt    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    rvec_tb_pkg::point_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.x_out;
      got.y = out_ch.y_out;
      got.z = out_ch.z_out;
      sb.check_point(got);
    end
  end

  task automatic send_point(logic kind, logic [AW-1:0] angle,
                            rvec_tb_pkg::coord_t x, rvec_tb_pkg::coord_t y,
                            rvec_tb_pkg::coord_t z);
    rvec_tb_pkg::point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.angle <= angle;
    in_ch.x_in  <= x;
    in_ch.y_in  <= y;
    in_ch.z_in  <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(kind, angle, p);
    if (kind == rvec_pkg::KIND_Z) z_axis_cnt++;
    else x_axis_cnt++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic rvec_tb_pkg::coord_t rand_coord();
    case ($urandom_range(7))
      0:       return rvec_tb_pkg::CMAX;
      1:       return rvec_tb_pkg::CMIN;
      2:       return rvec_tb_pkg::coord_t'(int'($urandom_range(131071)) - 65536);
      3:       return '0;
      default: return rvec_tb_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_angle();
    logic [AW-1:0] edges [8] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                                 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
    if ($urandom_range(9) == 0) return edges[$urandom_range(7)];
    return AW'($urandom);
  endfunction

  task automatic random_phase(int unsigned snd, int unsigned rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    repeat (PHASE_ITEMS)
      send_point(1'($urandom_range(1)), rand_angle(), rand_coord(), rand_coord(),
                 rand_coord());
  endtask

  initial begin
    logic [AW-1:0] dir_angles [8];
    bit failed;
    dir_angles   = '{16'h0000, 16'h2000, 16'h4000, 16'h8000,
                     16'hC000, 16'hFFFF, 16'h3FFF, 16'hC001};
    in_ch.valid  = 1'b0;
    in_ch.kind   = rvec_tb_pkg::KIND_X;
    in_ch.angle  = '0;
    in_ch.x_in   = '0;
    in_ch.y_in   = '0;
    in_ch.z_in   = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: both axes at quadrant edges, full-scale operands, clipping
    for (int i = 0; i < 16; i++)
      send_point(i[0] ? rvec_pkg::KIND_Z : rvec_tb_pkg::KIND_X, dir_angles[i / 2],
                 i[1] ? rvec_tb_pkg::CMAX : rvec_tb_pkg::CMIN,
                 i[2] ? rvec_tb_pkg::CMIN : rvec_tb_pkg::coord_t'(65536),
                 rvec_tb_pkg::CMAX - rvec_tb_pkg::coord_t'(i));
    send_point(rvec_tb_pkg::KIND_X, 16'h2000, '0, rvec_tb_pkg::CMAX, rvec_tb_pkg::CMAX);
    send_point(rvec_pkg::KIND_Z, 16'h6000, rvec_tb_pkg::CMIN, rvec_tb_pkg::CMIN, '0);
    send_point(rvec_pkg::KIND_Z, 16'h8000, rvec_tb_pkg::CMIN, rvec_tb_pkg::CMIN,
               rvec_tb_pkg::CMIN);
    send_point(rvec_tb_pkg::KIND_X, 16'h8000, rvec_tb_pkg::CMIN, rvec_tb_pkg::CMIN,
               rvec_tb_pkg::CMIN);
    drain();

    random_phase(31, 46);
    drain();
    random_phase(46, 31);
    drain();
    random_phase(0, 0);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    failed = (sb.mismatches != 0) || (sb.pending() != 0);
    if (sb.pending() != 0)
      $display("ERROR: %0d expected results never arrived", sb.pending());
    $display("Rotated %0d points (%0d about X, %0d about Z) under mixed stalls and gaps;",
             x_axis_cnt + z_axis_cnt, x_axis_cnt, z_axis_cnt);
    $display("%0d results matched, %0d mismatched, %0d coordinates clipped at range limits.",
             sb.matched, sb.mismatches, sb.saturated);
    if (!failed) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
